[rtl/core/tlbm_pkg.sv]
package tlbm_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROBE,
        ST_PWAIT,
        ST_FILL,
        ST_SWEEP,
        ST_DRAIN,
        ST_FIX,
        ST_RD,
        ST_RESP
    } tlbm_state_t;

    localparam logic [1:0] MODE_INIT = 2'd0;
    localparam logic [1:0] MODE_STEP = 2'd1;

    localparam logic [2:0] REG_INIT_TEMP   = 3'd0;
    localparam logic [2:0] REG_BATH_TEMP   = 3'd1;
    localparam logic [2:0] REG_RELAX_RATE  = 3'd2;
    localparam logic [2:0] REG_OMEGA_SKIN  = 3'd3;
    localparam logic [2:0] REG_OMEGA_BULK  = 3'd4;
    localparam logic [2:0] REG_GAIN_SKIN   = 3'd5;
    localparam logic [2:0] REG_GAIN_BULK   = 3'd6;
    localparam logic [2:0] REG_SKIN_NODES  = 3'd7;

    // floor(v / 6) is taken as ((v + SIDE_BIAS) * SIDE_RECIP >> 36) - SIDE_BIAS_Q.
    localparam logic signed [34:0] SIDE_BIAS   = 35'sd4294967298;
    localparam logic [33:0]        SIDE_RECIP  = 34'd11453246123;
    localparam logic signed [32:0] SIDE_BIAS_Q = 33'sd715827883;

    typedef struct packed {
        logic accept;
        logic probe;
        logic issue;
        logic fill_we;
        logic fix_we;
        logic steps_clear;
        logic load_out;
    } tlbm_cmd_t;

    typedef struct packed {
        logic probe_done;
        logic busy;
        logic out_free;
    } tlbm_status_t;

endpackage

[rtl/core/thermal_lbm_d1q3_with_bond_memory.sv]
// Initialize: one probe through the front of the pipeline, then one node written per cycle,
// then the report read. Time step: one node per cycle through the 11-stage read, compute and
// write-back pipeline of the node memories, its drain, one boundary write and the report read.
// Read: the report read alone. One request is worked at a time, so the next one is taken on
// the cycle after its result is loaded; a stalled result holds the block until the output
// register frees. Reset returns control and configuration to their defaults and clears the
// step counter; node memories hold nothing valid until the first initialize request.
module thermal_lbm_d1q3_with_bond_memory #(
    parameter int NODES = 1024,
    parameter int EQ_ROM_ENTRIES = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] node_index
    input  logic [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [31:0] temperature, [63:32] bond_length, [95:64] steps_done
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    import tlbm_pkg::*;

    localparam int AW = $clog2(NODES);

    tlbm_cmd_t     cmd;
    tlbm_status_t  status;
    logic [AW-1:0] cnt;

    tlbm_ctrl #(.NODES(NODES)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .mode(s_tuser),
        .status(status), .cmd(cmd), .cnt(cnt));

    tlbm_datapath #(.NODES(NODES), .EQ_ROM_ENTRIES(EQ_ROM_ENTRIES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .cnt(cnt), .status(status),
        .node_index(s_tdata[9:0]),
        .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata));

endmodule

[rtl/core/tlbm_ram.sv]
module tlbm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/tlbm_eq_rom.sv]
module tlbm_eq_rom #(
    parameter int ENTRIES = 2048,
    localparam int EW = $clog2(ENTRIES)
) (
    input  logic          clk,
    input  logic [EW-1:0] idx,
    output logic [31:0]   lo_val,
    output logic [31:0]   hi_val
);

    localparam int EvenDepth = (ENTRIES + 1) / 2;
    localparam int OddDepth  = ENTRIES / 2;
    localparam int HW        = $clog2(EvenDepth);
    localparam longint unsigned Den = 64'(ENTRIES - 1) * 64'd572887;
    localparam longint unsigned BondD0 = 64'd1078681036;
    localparam longint unsigned KexpTab [8] = '{
        64'd119881, 64'd325871, 64'd885808, 64'd2407877,
        64'd6545288, 64'd17791937, 64'd48363498, 64'd131465619
    };

    // Equilibrium bond length on an even grid over -128 .. +128 degrees,
    // exp() by a Taylor series on the fraction and a table for the integer part.
    function automatic logic [31:0] rom_entry(input longint unsigned k);
        longint unsigned num;
        longint unsigned n;
        longint unsigned f;
        longint unsigned sum;
        longint unsigned term;
        num  = 64'd1451500 * 64'(ENTRIES - 1) + 64'd2560000 * k;
        n    = (num / Den) & 64'd7;
        f    = ((num % Den) << 30) / Den;
        sum  = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int i = 1; i <= 20; i++)
        begin
            term = ((term * f) >> 30) / 64'(i);
            sum  = sum + term;
        end
        return 32'(BondD0 - ((KexpTab[n[2:0]] * sum) >> 32));
    endfunction

    logic [31:0] even_tab [EvenDepth];
    logic [31:0] odd_tab  [OddDepth];

    for (genvar k = 0; k < ENTRIES; k++)
    begin : g_tab
        localparam logic [31:0] Val = rom_entry(64'(k));
        if (k % 2 == 0)
        begin : g_even
            assign even_tab[k / 2] = Val;
        end
        else
        begin : g_odd
            assign odd_tab[k / 2] = Val;
        end
    end

    logic [HW-1:0] even_addr;
    logic [HW-1:0] odd_addr;
    logic [31:0]   even_q_reg;
    logic [31:0]   odd_q_reg;
    logic          sel_reg;

    // An odd index takes its upper neighbor from the next even row.
    assign odd_addr  = HW'(idx >> 1);
    assign even_addr = HW'(idx >> 1) + HW'(idx[0]);

    always_ff @(posedge clk)
    begin
        even_q_reg <= even_tab[even_addr];
        odd_q_reg  <= odd_tab[odd_addr];
        sel_reg    <= idx[0];
    end

    assign lo_val = sel_reg ? odd_q_reg : even_q_reg;
    assign hi_val = sel_reg ? even_q_reg : odd_q_reg;

endmodule

[rtl/core/tlbm_datapath.sv]
module tlbm_datapath #(
    parameter int NODES = 1024,
    parameter int EQ_ROM_ENTRIES = 2048,
    localparam int AW = $clog2(NODES)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tlbm_pkg::tlbm_cmd_t  cmd,
    input  logic [AW-1:0]        cnt,
    output tlbm_pkg::tlbm_status_t status,
    input  logic [9:0]           node_index,
    input  logic                 cfg_wen,
    input  logic [2:0]           cfg_addr,
    input  logic [31:0]          cfg_wdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [95:0]          m_tdata
);

    import tlbm_pkg::*;

    localparam int EW = $clog2(EQ_ROM_ENTRIES);
    localparam logic [AW-1:0] LastNode = AW'(NODES - 1);

    function automatic logic [31:0] sat32(input logic signed [39:0] v);
        if (v > 40'sd2147483647)
        begin
            return 32'h7FFF_FFFF;
        end
        if (v < -40'sd2147483648)
        begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [33:0] side_w(input logic signed [33:0] v);
        logic signed [34:0] s;
        s = 35'(v) + SIDE_BIAS;
        return s[33:0];
    endfunction

    function automatic logic signed [32:0] side_q(input logic [67:0] p);
        return $signed({1'b0, p[67:36]}) - SIDE_BIAS_Q;
    endfunction

    // Configuration registers.
    logic [31:0] init_temp_reg, bath_temp_reg, relax_rate_reg;
    logic [31:0] omega_skin_reg, omega_bulk_reg, gain_skin_reg, gain_bulk_reg;
    logic [10:0] skin_nodes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_temp_reg  <= 32'd1593835520;
            bath_temp_reg  <= 32'hEE00_0000;
            relax_rate_reg <= 32'd225506;
            omega_skin_reg <= 32'd2111630335;
            omega_bulk_reg <= 32'd2129164539;
            gain_skin_reg  <= 32'd1069292506;
            gain_bulk_reg  <= 32'd801971057;
            skin_nodes_reg <= 11'd10;
        end
        else if (cfg_wen)
        begin
            case (cfg_addr)
                REG_INIT_TEMP:  init_temp_reg  <= cfg_wdata;
                REG_BATH_TEMP:  bath_temp_reg  <= cfg_wdata;
                REG_RELAX_RATE: relax_rate_reg <= cfg_wdata;
                REG_OMEGA_SKIN: omega_skin_reg <= cfg_wdata;
                REG_OMEGA_BULK: omega_bulk_reg <= cfg_wdata;
                REG_GAIN_SKIN:  gain_skin_reg  <= cfg_wdata;
                REG_GAIN_BULK:  gain_bulk_reg  <= cfg_wdata;
                REG_SKIN_NODES: skin_nodes_reg <= cfg_wdata[10:0];
                default:        ;
            endcase
        end
    end

    // Weight splits of the two configured temperatures, kept current.
    logic [67:0] bath_prod_reg, init_prod_reg;
    logic signed [32:0] bath_side, init_side;
    logic [31:0] bath_rest, init_rest;

    always_ff @(posedge clk)
    begin
        bath_prod_reg <= side_w(34'($signed(bath_temp_reg))) * SIDE_RECIP;
        init_prod_reg <= side_w(34'($signed(init_temp_reg))) * SIDE_RECIP;
    end

    assign bath_side = side_q(bath_prod_reg);
    assign init_side = side_q(init_prod_reg);
    assign bath_rest = bath_temp_reg - {bath_side[30:0], 1'b0};
    assign init_rest = init_temp_reg - {init_side[30:0], 1'b0};

    // Memories.
    logic [31:0] rest_q, right_q, left_q, temp_q, bond_q;
    logic        rest_we, right_we, left_we, temp_we, bond_we;
    logic [AW-1:0] rest_wa, right_wa, left_wa, temp_wa, bond_wa, bond_ra;
    logic [31:0] rest_wd, right_wd, left_wd, temp_wd, bond_wd;
    logic [AW-1:0] node_reg;
    logic          in_range_reg;

    tlbm_ram #(.WIDTH(32), .DEPTH(NODES)) u_rest (
        .clk(clk), .we(rest_we), .waddr(rest_wa), .wdata(rest_wd),
        .raddr(cnt), .rdata(rest_q));
    tlbm_ram #(.WIDTH(32), .DEPTH(NODES)) u_right (
        .clk(clk), .we(right_we), .waddr(right_wa), .wdata(right_wd),
        .raddr(cnt), .rdata(right_q));
    tlbm_ram #(.WIDTH(32), .DEPTH(NODES)) u_left (
        .clk(clk), .we(left_we), .waddr(left_wa), .wdata(left_wd),
        .raddr(cnt), .rdata(left_q));
    tlbm_ram #(.WIDTH(32), .DEPTH(NODES)) u_temp (
        .clk(clk), .we(temp_we), .waddr(temp_wa), .wdata(temp_wd),
        .raddr(node_reg), .rdata(temp_q));
    tlbm_ram #(.WIDTH(32), .DEPTH(NODES)) u_bond (
        .clk(clk), .we(bond_we), .waddr(bond_wa), .wdata(bond_wd),
        .raddr(bond_ra), .rdata(bond_q));

    assign bond_ra = cmd.issue ? cnt : node_reg;

    // Read issue.
    logic rd_valid_reg, rd_probe_reg;
    logic [AW-1:0] rd_node_reg;

    // Stage A: temperature sum.
    logic a_valid_reg, a_probe_reg;
    logic [AW-1:0] a_node_reg;
    logic [31:0] a_t_reg, a_f0_reg, a_f1_reg, a_f2_reg, a_bond_reg;
    logic signed [33:0] sum_next;
    logic [31:0] a_t_next;

    assign sum_next = 34'($signed(rest_q)) + 34'($signed(right_q)) + 34'($signed(left_q));
    assign a_t_next = rd_probe_reg ? init_temp_reg : sat32(40'(sum_next));

    // Stage B: grid position and weight split of T.
    logic b_valid_reg, b_probe_reg;
    logic [AW-1:0] b_node_reg;
    logic [31:0] b_t_reg, b_f0_reg, b_f1_reg, b_f2_reg, b_bond_reg;
    logic [32+EW-1:0] b_s_reg;
    logic [67:0] b_tprod_reg;
    logic [31:0] a_u;

    assign a_u = {~a_t_reg[31], a_t_reg[30:0]};

    // Stage C: ROM address.
    logic c_valid_reg, c_probe_reg;
    logic [AW-1:0] c_node_reg;
    logic [31:0] c_t_reg, c_f0_reg, c_f1_reg, c_f2_reg, c_bond_reg, c_fr_reg;
    logic signed [32:0] c_es_reg;
    logic [EW-1:0] idx_raw, rom_idx;
    logic [31:0] rom_lo, rom_hi;

    assign idx_raw = b_s_reg[32 +: EW];
    assign rom_idx = (idx_raw > EW'(EQ_ROM_ENTRIES - 2)) ? EW'(EQ_ROM_ENTRIES - 2) : idx_raw;

    tlbm_eq_rom #(.ENTRIES(EQ_ROM_ENTRIES)) u_rom (
        .clk(clk), .idx(rom_idx), .lo_val(rom_lo), .hi_val(rom_hi));

    // Stage D: interpolation product.
    logic d_valid_reg, d_probe_reg, d_dec_reg;
    logic [AW-1:0] d_node_reg;
    logic [31:0] d_t_reg, d_f0_reg, d_f1_reg, d_f2_reg, d_bond_reg, d_a_reg;
    logic [63:0] d_prod_reg;
    logic signed [33:0] d_es_reg, d_er_reg;
    logic rom_dec;
    logic [31:0] rom_mag;

    assign rom_dec = rom_lo >= rom_hi;
    assign rom_mag = rom_dec ? rom_lo - rom_hi : rom_hi - rom_lo;

    // Stage E: bond difference and relaxation magnitudes.
    logic e_valid_reg, probe_done_reg;
    logic [AW-1:0] e_node_reg;
    logic [31:0] e_t_reg, e_f0_reg, e_f1_reg, e_f2_reg, e_bond_reg;
    logic signed [32:0] e_diff_reg;
    logic [35:0] e_rel0_reg, e_rel1_reg, e_rel2_reg;
    logic e_neg0_reg, e_neg1_reg, e_neg2_reg;
    logic [31:0] eq_next, init_bond_reg, d_om;
    logic signed [33:0] x0, x1, x2;
    logic [33:0] m0, m1, m2;
    logic [65:0] p0, p1, p2;

    assign eq_next = d_dec_reg ? d_a_reg - d_prod_reg[63:32] : d_a_reg + d_prod_reg[63:32];
    assign d_om = (32'(d_node_reg) < 32'(skin_nodes_reg)) ? omega_skin_reg : omega_bulk_reg;
    assign x0 = 34'($signed(d_f0_reg)) - d_er_reg;
    assign x1 = 34'($signed(d_f1_reg)) - d_es_reg;
    assign x2 = 34'($signed(d_f2_reg)) - d_es_reg;
    assign m0 = x0[33] ? 34'(-x0) : 34'(x0);
    assign m1 = x1[33] ? 34'(-x1) : 34'(x1);
    assign m2 = x2[33] ? 34'(-x2) : 34'(x2);
    assign p0 = 66'(m0) * 66'(d_om);
    assign p1 = 66'(m1) * 66'(d_om);
    assign p2 = 66'(m2) * 66'(d_om);

    // Stage F: bond change.
    logic f_valid_reg, f_dneg_reg;
    logic [AW-1:0] f_node_reg;
    logic [31:0] f_t_reg, f_f0_reg, f_f1_reg, f_f2_reg, f_bond_reg, f_dmag_reg;
    logic signed [36:0] f_rel0_reg, f_rel1_reg, f_rel2_reg;
    logic [31:0] e_dmag;
    logic [63:0] e_dprod;

    assign e_dmag  = e_diff_reg[32] ? 32'(-e_diff_reg) : e_diff_reg[31:0];
    assign e_dprod = 64'(e_dmag) * 64'(relax_rate_reg);

    // Stage G: heat source and new bond.
    logic g_valid_reg;
    logic [AW-1:0] g_node_reg;
    logic [31:0] g_t_reg, g_f0_reg, g_f1_reg, g_f2_reg, g_bond_reg;
    logic signed [36:0] g_rel0_reg, g_rel1_reg, g_rel2_reg;
    logic signed [33:0] g_src_reg;
    logic [31:0] f_gain;
    logic [63:0] f_sprod;

    assign f_gain  = (32'(f_node_reg) < 32'(skin_nodes_reg)) ? gain_skin_reg : gain_bulk_reg;
    assign f_sprod = 64'(f_dmag_reg) * 64'(f_gain);

    // Stage H: weight split of the source.
    logic h_valid_reg;
    logic [AW-1:0] h_node_reg;
    logic [31:0] h_t_reg, h_f0_reg, h_f1_reg, h_f2_reg, h_bond_reg;
    logic signed [36:0] h_rel0_reg, h_rel1_reg, h_rel2_reg;
    logic signed [33:0] h_src_reg;
    logic [67:0] h_prod_reg;

    // Stage I: source weights.
    logic i_valid_reg;
    logic [AW-1:0] i_node_reg;
    logic [31:0] i_t_reg, i_f0_reg, i_f1_reg, i_f2_reg, i_bond_reg;
    logic signed [36:0] i_rel0_reg, i_rel1_reg, i_rel2_reg;
    logic signed [32:0] i_ss_reg;
    logic signed [34:0] i_sr_reg;
    logic signed [32:0] h_ss;

    assign h_ss = side_q(h_prod_reg);

    // Stage J: new distributions, written back from here.
    logic j_valid_reg;
    logic [AW-1:0] j_node_reg;
    logic [31:0] j_t_reg, j_bond_reg, j_nx0_reg, j_nx1_reg, j_nx2_reg;
    logic [31:0] fix_right_reg, fix_left_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
            d_valid_reg    <= 1'b0;
            e_valid_reg    <= 1'b0;
            probe_done_reg <= 1'b0;
            f_valid_reg    <= 1'b0;
            g_valid_reg    <= 1'b0;
            h_valid_reg    <= 1'b0;
            i_valid_reg    <= 1'b0;
            j_valid_reg    <= 1'b0;
        end
        else
        begin
            rd_valid_reg   <= cmd.issue | cmd.probe;
            a_valid_reg    <= rd_valid_reg;
            b_valid_reg    <= a_valid_reg;
            c_valid_reg    <= b_valid_reg;
            d_valid_reg    <= c_valid_reg;
            e_valid_reg    <= d_valid_reg & ~d_probe_reg;
            probe_done_reg <= d_valid_reg & d_probe_reg;
            f_valid_reg    <= e_valid_reg;
            g_valid_reg    <= f_valid_reg;
            h_valid_reg    <= g_valid_reg;
            i_valid_reg    <= h_valid_reg;
            j_valid_reg    <= i_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_probe_reg <= cmd.probe;
        rd_node_reg  <= cnt;

        a_probe_reg <= rd_probe_reg;
        a_node_reg  <= rd_node_reg;
        a_t_reg     <= a_t_next;
        a_f0_reg    <= rest_q;
        a_f1_reg    <= right_q;
        a_f2_reg    <= left_q;
        a_bond_reg  <= bond_q;

        b_probe_reg <= a_probe_reg;
        b_node_reg  <= a_node_reg;
        b_t_reg     <= a_t_reg;
        b_f0_reg    <= a_f0_reg;
        b_f1_reg    <= a_f1_reg;
        b_f2_reg    <= a_f2_reg;
        b_bond_reg  <= a_bond_reg;
        b_s_reg     <= (32+EW)'(a_u) * (32+EW)'(EQ_ROM_ENTRIES - 1);
        b_tprod_reg <= side_w(34'($signed(a_t_reg))) * SIDE_RECIP;

        c_probe_reg <= b_probe_reg;
        c_node_reg  <= b_node_reg;
        c_t_reg     <= b_t_reg;
        c_f0_reg    <= b_f0_reg;
        c_f1_reg    <= b_f1_reg;
        c_f2_reg    <= b_f2_reg;
        c_bond_reg  <= b_bond_reg;
        c_fr_reg    <= b_s_reg[31:0];
        c_es_reg    <= side_q(b_tprod_reg);

        d_probe_reg <= c_probe_reg;
        d_node_reg  <= c_node_reg;
        d_t_reg     <= c_t_reg;
        d_f0_reg    <= c_f0_reg;
        d_f1_reg    <= c_f1_reg;
        d_f2_reg    <= c_f2_reg;
        d_bond_reg  <= c_bond_reg;
        d_a_reg     <= rom_lo;
        d_dec_reg   <= rom_dec;
        d_prod_reg  <= 64'(rom_mag) * 64'(c_fr_reg);
        d_es_reg    <= 34'(c_es_reg);
        d_er_reg    <= 34'($signed(c_t_reg)) - 34'(c_es_reg) - 34'(c_es_reg);

        if (d_valid_reg && d_probe_reg)
        begin
            init_bond_reg <= eq_next;
        end
        e_node_reg <= d_node_reg;
        e_t_reg    <= d_t_reg;
        e_f0_reg   <= d_f0_reg;
        e_f1_reg   <= d_f1_reg;
        e_f2_reg   <= d_f2_reg;
        e_bond_reg <= d_bond_reg;
        e_diff_reg <= $signed({1'b0, eq_next}) - $signed({1'b0, d_bond_reg});
        e_rel0_reg <= p0[65:30];
        e_rel1_reg <= p1[65:30];
        e_rel2_reg <= p2[65:30];
        e_neg0_reg <= x0[33];
        e_neg1_reg <= x1[33];
        e_neg2_reg <= x2[33];

        f_node_reg <= e_node_reg;
        f_t_reg    <= e_t_reg;
        f_f0_reg   <= e_f0_reg;
        f_f1_reg   <= e_f1_reg;
        f_f2_reg   <= e_f2_reg;
        f_bond_reg <= e_bond_reg;
        f_dmag_reg <= e_dprod[63:32];
        f_dneg_reg <= e_diff_reg[32];
        f_rel0_reg <= e_neg0_reg ? -$signed({1'b0, e_rel0_reg}) : $signed({1'b0, e_rel0_reg});
        f_rel1_reg <= e_neg1_reg ? -$signed({1'b0, e_rel1_reg}) : $signed({1'b0, e_rel1_reg});
        f_rel2_reg <= e_neg2_reg ? -$signed({1'b0, e_rel2_reg}) : $signed({1'b0, e_rel2_reg});

        g_node_reg <= f_node_reg;
        g_t_reg    <= f_t_reg;
        g_f0_reg   <= f_f0_reg;
        g_f1_reg   <= f_f1_reg;
        g_f2_reg   <= f_f2_reg;
        g_bond_reg <= f_dneg_reg ? f_bond_reg - f_dmag_reg : f_bond_reg + f_dmag_reg;
        g_src_reg  <= f_dneg_reg ? -$signed({2'b00, f_sprod[63:32]})
                                 : $signed({2'b00, f_sprod[63:32]});
        g_rel0_reg <= f_rel0_reg;
        g_rel1_reg <= f_rel1_reg;
        g_rel2_reg <= f_rel2_reg;

        h_node_reg <= g_node_reg;
        h_t_reg    <= g_t_reg;
        h_f0_reg   <= g_f0_reg;
        h_f1_reg   <= g_f1_reg;
        h_f2_reg   <= g_f2_reg;
        h_bond_reg <= g_bond_reg;
        h_src_reg  <= g_src_reg;
        h_prod_reg <= side_w(g_src_reg) * SIDE_RECIP;
        h_rel0_reg <= g_rel0_reg;
        h_rel1_reg <= g_rel1_reg;
        h_rel2_reg <= g_rel2_reg;

        i_node_reg <= h_node_reg;
        i_t_reg    <= h_t_reg;
        i_f0_reg   <= h_f0_reg;
        i_f1_reg   <= h_f1_reg;
        i_f2_reg   <= h_f2_reg;
        i_bond_reg <= h_bond_reg;
        i_ss_reg   <= h_ss;
        i_sr_reg   <= 35'(h_src_reg) - 35'(h_ss) - 35'(h_ss);
        i_rel0_reg <= h_rel0_reg;
        i_rel1_reg <= h_rel1_reg;
        i_rel2_reg <= h_rel2_reg;

        j_node_reg <= i_node_reg;
        j_t_reg    <= i_t_reg;
        j_bond_reg <= i_bond_reg;
        j_nx0_reg  <= sat32(40'($signed(i_f0_reg)) - 40'(i_rel0_reg) + 40'(i_sr_reg));
        j_nx1_reg  <= sat32(40'($signed(i_f1_reg)) - 40'(i_rel1_reg) + 40'(i_ss_reg));
        j_nx2_reg  <= sat32(40'($signed(i_f2_reg)) - 40'(i_rel2_reg) + 40'(i_ss_reg));

        // Cold bath at the first node, reflecting wall at the last node.
        if (j_valid_reg && j_node_reg == '0)
        begin
            fix_right_reg <= sat32(40'(bath_side) + 40'(bath_side) - 40'($signed(j_nx2_reg)));
        end
        if (j_valid_reg && j_node_reg == LastNode)
        begin
            fix_left_reg <= j_nx1_reg;
        end
    end

    // Write-back: streaming moves right-going values up one node and left-going down.
    always_comb
    begin
        rest_we  = cmd.fill_we | j_valid_reg;
        rest_wa  = cmd.fill_we ? cnt : j_node_reg;
        rest_wd  = cmd.fill_we ? init_rest : ((j_node_reg == '0) ? bath_rest : j_nx0_reg);

        right_we = cmd.fill_we | cmd.fix_we | (j_valid_reg & (j_node_reg != LastNode));
        right_wa = cmd.fill_we ? cnt : (cmd.fix_we ? '0 : j_node_reg + AW'(1));
        right_wd = cmd.fill_we ? init_side[31:0] : (cmd.fix_we ? fix_right_reg : j_nx1_reg);

        left_we  = cmd.fill_we | cmd.fix_we | (j_valid_reg & (j_node_reg != '0));
        left_wa  = cmd.fill_we ? cnt : (cmd.fix_we ? LastNode : j_node_reg - AW'(1));
        left_wd  = cmd.fill_we ? init_side[31:0] : (cmd.fix_we ? fix_left_reg : j_nx2_reg);

        temp_we  = cmd.fill_we | j_valid_reg;
        temp_wa  = cmd.fill_we ? cnt : j_node_reg;
        temp_wd  = cmd.fill_we ? init_temp_reg
                               : ((j_node_reg == '0) ? bath_temp_reg : j_t_reg);

        bond_we  = cmd.fill_we | j_valid_reg;
        bond_wa  = cmd.fill_we ? cnt : j_node_reg;
        bond_wd  = cmd.fill_we ? init_bond_reg : j_bond_reg;
    end

    // Step counter, requested node and output register.
    logic [31:0] steps_reg;
    logic        m_valid_reg;
    logic [95:0] m_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.steps_clear)
            begin
                steps_reg <= '0;
            end
            else if (cmd.fix_we)
            begin
                steps_reg <= steps_reg + 32'd1;
            end
            if (cmd.load_out)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            node_reg     <= AW'({22'd0, node_index});
            in_range_reg <= {22'd0, node_index} < 32'(NODES);
        end
        if (cmd.load_out)
        begin
            m_data_reg <= {steps_reg,
                           in_range_reg ? bond_q : 32'd0,
                           in_range_reg ? temp_q : 32'd0};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign status.probe_done = probe_done_reg;
    assign status.busy       = rd_valid_reg | a_valid_reg | b_valid_reg | c_valid_reg
                             | d_valid_reg | e_valid_reg | f_valid_reg | g_valid_reg
                             | h_valid_reg | i_valid_reg | j_valid_reg;
    assign status.out_free   = ~m_valid_reg | m_tready;

endmodule

[rtl/core/tlbm_ctrl.sv]
module tlbm_ctrl #(
    parameter int NODES = 1024,
    localparam int AW = $clog2(NODES)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [1:0]             mode,
    input  tlbm_pkg::tlbm_status_t status,
    output tlbm_pkg::tlbm_cmd_t    cmd,
    output logic [AW-1:0]          cnt
);

    import tlbm_pkg::*;

    tlbm_state_t state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic last;

    assign last = cnt_reg == AW'(NODES - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (mode)
                        MODE_INIT: state_next = ST_PROBE;
                        MODE_STEP: state_next = ST_SWEEP;
                        default:   state_next = ST_RD;
                    endcase
                end
            end
            ST_PROBE: state_next = ST_PWAIT;
            ST_PWAIT:
            begin
                if (status.probe_done)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (last)
                begin
                    state_next = ST_RD;
                end
            end
            ST_SWEEP:
            begin
                if (last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.busy)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:   state_next = ST_RD;
            ST_RD:    state_next = ST_RESP;
            ST_RESP:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        cnt_next = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_PROBE:
            begin
                cmd.probe       = 1'b1;
                cmd.steps_clear = 1'b1;
            end
            ST_FILL:
            begin
                cmd.fill_we = 1'b1;
                cnt_next    = cnt_reg + AW'(1);
            end
            ST_SWEEP:
            begin
                cmd.issue = 1'b1;
                cnt_next  = cnt_reg + AW'(1);
            end
            ST_FIX:   cmd.fix_we = 1'b1;
            ST_RESP:  cmd.load_out = status.out_free;
            default:  ;
        endcase
    end

    assign cnt = cnt_reg;

endmodule

[tb/tlbm_checker.sv]
`timescale 1ns / 1ps

module tlbm_checker #(
    parameter int NODES = 1024,
    parameter int EQ_ROM_ENTRIES = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata,
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    output int          fail_count,
    output int          pending
);

    import tlbm_pkg::*;

    localparam longint BOND_D0 = 64'd1078681036;

    typedef struct packed {
        logic [31:0] steps_done;
        logic [31:0] bond_length;
        logic [31:0] temperature;
    } node_report_t;

    longint unsigned exp_scale [8] = '{
        64'd119881, 64'd325871, 64'd885808, 64'd2407877,
        64'd6545288, 64'd17791937, 64'd48363498, 64'd131465619
    };

    logic [31:0] eq_curve [EQ_ROM_ENTRIES];

    logic [31:0] init_temp, bath_temp, relax_rate;
    logic [31:0] omega_skin, omega_bulk, gain_skin, gain_bulk;
    logic [10:0] skin_count;

    int          f_rest [NODES];
    int          f_right [NODES];
    int          f_left [NODES];
    int          temp_mem [NODES];
    logic [31:0] bond_mem [NODES];
    int          nx_rest [NODES];
    int          nx_right [NODES];
    int          nx_left [NODES];
    logic [31:0] step_count;

    node_report_t report_queue [$];

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint floor_sixth(longint v);
        longint q;
        q = v / 6;
        if (v % 6 != 0 && v < 0)
            q = q - 1;
        return q;
    endfunction

    // Sign-magnitude product, truncated toward zero, wrapping like 64-bit hardware.
    function automatic longint scaled_product(longint a, longint unsigned b, int sh);
        longint unsigned m;
        longint unsigned r;
        m = (a < 0) ? longint'(-a) : longint'(a);
        r = (m * b) >> sh;
        return (a < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [31:0] bond_target(int t);
        longint unsigned u;
        longint unsigned s;
        longint unsigned idx;
        longint unsigned fr;
        longint unsigned a;
        longint unsigned b;
        u = longint'(t) + 64'sd2147483648;
        s = u * (EQ_ROM_ENTRIES - 1);
        idx = s >> 32;
        fr = s & 64'hFFFF_FFFF;
        if (idx > EQ_ROM_ENTRIES - 2)
            idx = EQ_ROM_ENTRIES - 2;
        a = eq_curve[idx];
        b = eq_curve[idx + 1];
        if (a >= b)
            return 32'(a - (((a - b) * fr) >> 32));
        return 32'(a + (((b - a) * fr) >> 32));
    endfunction

    task automatic build_curve();
        longint unsigned den;
        longint unsigned num;
        longint unsigned n;
        longint unsigned f;
        longint unsigned sum;
        longint unsigned term;
        den = longint'(EQ_ROM_ENTRIES - 1) * 572887;
        for (int k = 0; k < EQ_ROM_ENTRIES; k++)
        begin
            num = 64'd1451500 * (EQ_ROM_ENTRIES - 1) + 64'd2560000 * k;
            n = (num / den) & 7;
            f = ((num % den) << 30) / den;
            sum = 64'd1 << 30;
            term = 64'd1 << 30;
            for (int i = 1; i <= 20; i++)
            begin
                term = ((term * f) >> 30) / i;
                sum = sum + term;
            end
            eq_curve[k] = 32'(BOND_D0 - longint'((exp_scale[n] * sum) >> 32));
        end
    endtask

    task automatic grid_fill();
        int          t;
        longint      s;
        logic [31:0] b;
        t = int'(init_temp);
        s = floor_sixth(t);
        b = bond_target(t);
        for (int i = 0; i < NODES; i++)
        begin
            temp_mem[i] = t;
            bond_mem[i] = b;
            f_right[i] = int'(s);
            f_left[i] = int'(s);
            f_rest[i] = int'(longint'(t) - 2 * s);
        end
        step_count = '0;
    endtask

    task automatic grid_advance();
        longint          bath;
        longint          bath_side;
        longint          f0, f1, f2;
        int              t;
        longint unsigned om, gn;
        longint          delta, heat, es, er, hs, hr;
        bath = longint'(int'(bath_temp));
        bath_side = floor_sixth(bath);
        for (int i = 0; i < NODES; i++)
        begin
            f0 = f_rest[i];
            f1 = f_right[i];
            f2 = f_left[i];
            t = int'(clamp32(f0 + f1 + f2));
            om = (i < skin_count) ? omega_skin : omega_bulk;
            gn = (i < skin_count) ? gain_skin : gain_bulk;
            temp_mem[i] = t;
            delta = scaled_product(longint'(bond_target(t)) - longint'(bond_mem[i]),
                                   relax_rate, 32);
            bond_mem[i] = 32'(longint'(bond_mem[i]) + delta);
            heat = scaled_product(delta, gn, 32);
            es = floor_sixth(t);
            er = longint'(t) - 2 * es;
            hs = floor_sixth(heat);
            hr = heat - 2 * hs;
            nx_rest[i] = int'(clamp32(f0 - scaled_product(f0 - er, om, 30) + hr));
            nx_right[i] = int'(clamp32(f1 - scaled_product(f1 - es, om, 30) + hs));
            nx_left[i] = int'(clamp32(f2 - scaled_product(f2 - es, om, 30) + hs));
        end
        for (int i = 1; i + 1 < NODES; i++)
        begin
            f_rest[i] = nx_rest[i];
            f_right[i] = nx_right[i - 1];
            f_left[i] = nx_left[i + 1];
        end
        // Cold bath at node zero bounces back anti-symmetrically; the far end reflects.
        temp_mem[0] = int'(bath);
        f_right[0] = int'(clamp32(2 * bath_side - longint'(nx_left[0])));
        f_rest[0] = int'(bath - 2 * bath_side);
        f_left[0] = nx_left[1];
        f_rest[NODES - 1] = nx_rest[NODES - 1];
        f_left[NODES - 1] = nx_right[NODES - 1];
        f_right[NODES - 1] = nx_right[NODES - 2];
        step_count = step_count + 1;
    endtask

    initial
    begin
        build_curve();
        step_count = '0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count <= '0;
            init_temp  <= 32'd1593835520;
            bath_temp  <= 32'hEE00_0000;
            relax_rate <= 32'd225506;
            omega_skin <= 32'd2111630335;
            omega_bulk <= 32'd2129164539;
            gain_skin  <= 32'd1069292506;
            gain_bulk  <= 32'd801971057;
            skin_count <= 11'd10;
        end
        else if (cfg_wen)
        begin
            case (cfg_addr)
                REG_INIT_TEMP:  init_temp <= cfg_wdata;
                REG_BATH_TEMP:  bath_temp <= cfg_wdata;
                REG_RELAX_RATE: relax_rate <= cfg_wdata;
                REG_OMEGA_SKIN: omega_skin <= cfg_wdata;
                REG_OMEGA_BULK: omega_bulk <= cfg_wdata;
                REG_GAIN_SKIN:  gain_skin <= cfg_wdata;
                REG_GAIN_BULK:  gain_bulk <= cfg_wdata;
                REG_SKIN_NODES: skin_count <= cfg_wdata[10:0];
                default: ;
            endcase
        end
    end

    always @(posedge clk)
    begin : predict_and_check
        int           idx;
        node_report_t want;
        node_report_t got;
        if (rst_n && s_tvalid && s_tready)
        begin
            idx = int'(s_tdata[9:0]);
            if (s_tuser == MODE_INIT)
                grid_fill();
            else if (s_tuser == MODE_STEP)
                grid_advance();
            if (idx < NODES)
            begin
                want.temperature = temp_mem[idx];
                want.bond_length = bond_mem[idx];
            end
            else
            begin
                want.temperature = '0;
                want.bond_length = '0;
            end
            want.steps_done = step_count;
            report_queue.push_back(want);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (report_queue.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("ERROR: result with nothing expected: %h", m_tdata);
            end
            else
            begin
                want = report_queue.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR: temperature exp %h got %h, bond exp %h got %h, steps exp %0d got %0d",
                                 want.temperature, got.temperature, want.bond_length,
                                 got.bond_length, want.steps_done, got.steps_done);
                end
            end
        end
        pending = report_queue.size();
    end

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

endmodule

[tb/tb_thermal_lbm_d1q3_with_bond_memory.sv]
`timescale 1ns / 1ps

module tb_thermal_lbm_d1q3_with_bond_memory;
    import tlbm_pkg::*;

    localparam int NODES = 1024;
    localparam logic [1:0] MODE_READ = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int IDLE_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic        cfg_wen;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_wdata;

    int fail_count;
    int pending;
    int hold_off;
    bit no_gaps;
    int idle_cycles;
    int mode_count [4];
    int phase_count;

    thermal_lbm_d1q3_with_bond_memory #(.NODES(NODES)) dut (.*);

    tlbm_checker #(.NODES(NODES)) u_checker (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receiver: random stalls, always ready when gaps are off, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            m_tready = 1'b0;
            hold_off = hold_off - 1;
        end
        else if (no_gaps)
            m_tready = 1'b1;
        else if ($urandom_range(0, 19) == 0)
            m_tready = 1'b0;
        else if ($urandom_range(0, 3) == 0)
            m_tready = ~m_tready;
        else
            m_tready = 1'b1;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        if (no_gaps)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(0, 2);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_request(logic [1:0] mode, logic [9:0] node);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = mode;
        s_tdata = {6'b0, node};
        mode_count[mode]++;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic settle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (NODES + 30) @(posedge clk);
    endtask

    task automatic write_settings(logic [31:0] vals [8]);
        for (int r = 0; r < 8; r++)
        begin
            @(negedge clk);
            cfg_wen = 1'b1;
            cfg_addr = 3'(r);
            cfg_wdata = vals[r];
        end
        @(negedge clk);
        cfg_wen = 1'b0;
        phase_count++;
    endtask

    function automatic logic [1:0] random_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return MODE_INIT;
        if (r < 50)
            return MODE_STEP;
        if (r < 95)
            return MODE_READ;
        return MODE_SPARE;
    endfunction

    task automatic random_phase(int count);
        send_request(MODE_INIT, 10'($urandom_range(0, NODES - 1)));
        for (int n = 0; n < count; n++)
            send_request(random_mode(), 10'($urandom));
    endtask

    logic [31:0] regs [8];

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = MODE_READ;
        m_tready = 1'b0;
        cfg_wen = 1'b0;
        cfg_addr = REG_INIT_TEMP;
        cfg_wdata = '0;
        hold_off = 0;
        no_gaps = 1'b0;
        phase_count = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (NODES + 30) @(posedge clk);

        // Settings as the block's reset values.
        regs = '{32'd1593835520, 32'hEE00_0000, 32'd225506, 32'd2111630335,
                 32'd2129164539, 32'd1069292506, 32'd801971057, 32'd10};
        write_settings(regs);
        send_request(MODE_INIT, 10'd0);
        send_request(MODE_READ, 10'd1023);
        send_request(MODE_STEP, 10'd0);
        send_request(MODE_STEP, 10'd1023);
        send_request(MODE_READ, 10'd0);
        send_request(MODE_SPARE, 10'd9);
        send_request(MODE_STEP, 10'd10);
        send_request(MODE_READ, 10'd1022);
        send_request(MODE_INIT, 10'd1023);
        send_request(MODE_STEP, 10'h2AA);
        send_request(MODE_STEP, 10'h155);
        settle();

        // Extremes: saturating temperatures, full rates, every node skin.
        regs = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1024};
        write_settings(regs);
        send_request(MODE_INIT, 10'd5);
        for (int n = 0; n < 6; n++)
            send_request(n[0] ? MODE_READ : MODE_STEP, 10'($urandom));
        settle();

        regs = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
        write_settings(regs);
        send_request(MODE_INIT, 10'd0);
        send_request(MODE_STEP, 10'd1023);
        send_request(MODE_STEP, 10'd1);
        settle();

        for (int p = 0; p < 6; p++)
        begin
            regs[0] = (p % 2) ? $urandom : 32'($signed($urandom_range(0, 32'h6000_0000)));
            regs[1] = (p % 3) ? $urandom : 32'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000;
            regs[2] = (p == 5) ? 32'hFFFF_FFFF : $urandom;
            regs[3] = $urandom_range(0, 32'h8000_0000);
            regs[4] = (p == 4) ? 32'hFFFF_FFFF : $urandom_range(0, 32'h8000_0000);
            regs[5] = $urandom;
            regs[6] = $urandom;
            regs[7] = (p == 2) ? 32'd1024 : (p == 3) ? 32'd2047 : $urandom_range(0, 1024);
            write_settings(regs);
            no_gaps = (p == 1);
            if (p == 2)
            begin
                // Receiver holds off long enough for the input to back up.
                hold_off = 4000;
                for (int n = 0; n < 6; n++)
                    send_request(MODE_READ, 10'($urandom));
            end
            random_phase(58);
            no_gaps = 1'b0;
            settle();
        end

        $display("Covered %0d initializes, %0d steps, %0d reads and %0d spare-mode reads",
                 mode_count[MODE_INIT], mode_count[MODE_STEP], mode_count[MODE_READ],
                 mode_count[MODE_SPARE]);
        $display("over %0d register settings, including saturating extremes.", phase_count);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
rtl/core/tlbm_pkg.sv
rtl/core/tlbm_ram.sv
rtl/core/tlbm_eq_rom.sv
rtl/core/tlbm_datapath.sv
rtl/core/tlbm_ctrl.sv
rtl/core/thermal_lbm_d1q3_with_bond_memory.sv
tb/tlbm_checker.sv
tb/tb_thermal_lbm_d1q3_with_bond_memory.sv
